// File: sv/tfr_pkg.sv
// ----------------------------------------------------------------------------
// Telemetry frame receiver package
// Shared constants, parser phases and the per-item result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfr_pkg;

	// Frame layout and limits
	localparam int unsigned MAX_PAYLOAD = 252;
	localparam logic [7:0]  SYNC_BYTE   = 8'h55;
	localparam logic [7:0]  TRAIL_BYTE  = 8'hAA;

	// Two banks of 256 bytes each
	localparam int unsigned BANK_SIZE   = 256;
	localparam int unsigned STORE_DEPTH = 2 * BANK_SIZE;
	localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

	// Configuration space
	localparam int unsigned CFG_AW                = 3;
	localparam logic [CFG_AW-1:0] ADDR_PROTO_VER  = 3'd0;

	// Commands
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Result event codes
	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_GOOD = 2'd1,
		EV_DROP = 2'd2,
		EV_READ = 2'd3
	} event_t;

	// Parser phases
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_TYPE  = 3'd1,
		PH_LEN   = 3'd2,
		PH_IDLO  = 3'd3,
		PH_IDHI  = 3'd4,
		PH_BODY  = 3'd5,
		PH_TRAIL = 3'd6
	} phase_t;

	// Result fields known at accept time (the read byte joins after the RAM's registered read)
	typedef struct packed {
		event_t       ev;
		logic [7:0]   ftype;
		logic [15:0]  fid;
		logic [7:0]   flen;
		logic         rok;
		logic [31:0]  good;
		logic [31:0]  total;
	} result_t;

endpackage

`default_nettype wire

// File: sv/tfr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 512
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: sv/telemetry_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// Telemetry frame receiver
// Deframes sync/type/length/id/payload/checksum/trailer byte frames into a
// two-bank payload RAM and serves reversed-order reads of the delivered frame.
// ----------------------------------------------------------------------------
// After its item is accepted, a result passes through stage 1, where it waits for
// the RAM read data, and then the output register.
// Throughput: one item per cycle unless the output stalls; each byte is one
// parser update, a payload byte also one RAM write; a read is one RAM read.
// Reset clears the parser, the last-frame fields, both counters and the
// version register; the payload RAM is not cleared and needs no sweep.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_frame_receiver_top #(
	parameter int unsigned MAX_PAYLOAD = tfr_pkg::MAX_PAYLOAD
) (
	input  wire         clk,
	input  wire         arst_n,
	// APB-style configuration port
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire [tfr_pkg::CFG_AW-1:0]  paddr,
	input  wire [31:0]                 pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// Input channel
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         cmd,
	input  wire  [7:0]  data_byte,
	input  wire  [7:0]  read_index,
	// Output channel
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  frame_event,
	output logic [7:0]  frame_type,
	output logic [15:0] frame_id,
	output logic [7:0]  frame_length,
	output logic [7:0]  read_byte,
	output logic        read_ok,
	output logic [31:0] frames_good,
	output logic [31:0] payload_bytes_total
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	// Configuration register
	logic [7:0] proto_ver_q;

	// Parser and delivered-frame state
	tfr_pkg::phase_t phase_q, phase_d;
	logic [7:0]  cur_type_q, cur_type_d;
	logic [7:0]  cur_len_q, cur_len_d;
	logic [15:0] cur_id_q, cur_id_d;
	logic [7:0]  pos_q, pos_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  sent_q, sent_d;
	logic        bank_q, bank_d;
	logic [7:0]  last_type_q, last_type_d;
	logic [15:0] last_id_q, last_id_d;
	logic [7:0]  last_len_q, last_len_d;
	logic [31:0] good_q, good_d;
	logic [31:0] total_q, total_d;

	// Pipeline
	logic                 in_fire;
	logic                 s1_valid_s1;
	tfr_pkg::result_t     s1_res_s1;
	logic                 s1_fresh_s1;
	logic [7:0]           s1_hold_s1;
	logic                 s1_move;
	logic                 out_valid_q;
	tfr_pkg::result_t     out_res_q;
	logic [7:0]           out_byte_q;
	tfr_pkg::result_t     res_d;
	logic [7:0]           s1_byte;

	// RAM ports
	logic                          ram_we;
	logic [tfr_pkg::STORE_AW-1:0]  ram_waddr;
	logic                          ram_re;
	logic [tfr_pkg::STORE_AW-1:0]  ram_raddr;
	logic [7:0]                    ram_rdata;
	logic                          rd_hit;
	logic [7:0]                    rd_pos;

	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proto_ver_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr == tfr_pkg::ADDR_PROTO_VER) begin
			proto_ver_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == tfr_pkg::ADDR_PROTO_VER) begin
			prdata = {24'd0, proto_ver_q};
		end
	end

	// Handshakes
	assign s1_move  = s1_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_s1 || s1_move;
	assign in_fire  = in_valid && in_ready;

	// Parser next state
	always_comb begin
		phase_d     = phase_q;
		cur_type_d  = cur_type_q;
		cur_len_d   = cur_len_q;
		cur_id_d    = cur_id_q;
		pos_d       = pos_q;
		sum_d       = sum_q;
		sent_d      = sent_q;
		bank_d      = bank_q;
		last_type_d = last_type_q;
		last_id_d   = last_id_q;
		last_len_d  = last_len_q;
		good_d      = good_q;
		total_d     = total_q;
		if (cmd == tfr_pkg::CMD_PUSH) begin
			case (phase_q)
				tfr_pkg::PH_IDLE: begin
					if (data_byte == tfr_pkg::SYNC_BYTE) begin
						phase_d = tfr_pkg::PH_TYPE;
					end
				end
				tfr_pkg::PH_TYPE: begin
					cur_type_d = data_byte;
					pos_d      = '0;
					sum_d      = data_byte + proto_ver_q;
					phase_d    = tfr_pkg::PH_LEN;
				end
				tfr_pkg::PH_LEN: begin
					cur_len_d = data_byte;
					phase_d   = (data_byte > MAX_LEN) ? tfr_pkg::PH_IDLE : tfr_pkg::PH_IDLO;
				end
				tfr_pkg::PH_IDLO: begin
					cur_id_d = {8'd0, data_byte};
					phase_d  = tfr_pkg::PH_IDHI;
				end
				tfr_pkg::PH_IDHI: begin
					cur_id_d = {data_byte, cur_id_q[7:0]};
					phase_d  = tfr_pkg::PH_BODY;
				end
				tfr_pkg::PH_BODY: begin
					if (pos_q < cur_len_q) begin
						sum_d = sum_q + data_byte;
						pos_d = pos_q + 8'd1;
					end else begin
						sent_d  = data_byte;
						phase_d = tfr_pkg::PH_TRAIL;
					end
				end
				tfr_pkg::PH_TRAIL: begin
					if (data_byte == tfr_pkg::TRAIL_BYTE && sum_q == sent_q) begin
						bank_d      = !bank_q;
						last_type_d = cur_type_q;
						last_id_d   = cur_id_q;
						last_len_d  = cur_len_q;
						good_d      = good_q + 32'd1;
						total_d     = total_q + {24'd0, cur_len_q};
					end
					phase_d = tfr_pkg::PH_IDLE;
				end
				default: begin
					phase_d = tfr_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// Parser outputs: event, RAM write and RAM read
	always_comb begin
		res_d.ev = tfr_pkg::EV_NONE;
		ram_we   = 1'b0;
		rd_hit   = read_index < last_len_q;
		rd_pos   = last_len_q - 8'd1 - read_index;
		if (cmd == tfr_pkg::CMD_READ) begin
			res_d.ev = tfr_pkg::EV_READ;
		end else begin
			case (phase_q)
				tfr_pkg::PH_BODY: begin
					ram_we = in_fire && (pos_q < cur_len_q);
				end
				tfr_pkg::PH_TRAIL: begin
					res_d.ev = (data_byte == tfr_pkg::TRAIL_BYTE && sum_q == sent_q) ?
						tfr_pkg::EV_GOOD : tfr_pkg::EV_DROP;
				end
				default: begin
					res_d.ev = tfr_pkg::EV_NONE;
				end
			endcase
		end
		res_d.ftype = last_type_d;
		res_d.fid   = last_id_d;
		res_d.flen  = last_len_d;
		res_d.rok   = (cmd == tfr_pkg::CMD_READ) && rd_hit;
		res_d.good  = good_d;
		res_d.total = total_d;
	end

	assign ram_waddr = {!bank_q, pos_q};
	assign ram_re    = in_fire && (cmd == tfr_pkg::CMD_READ);
	assign ram_raddr = {bank_q, rd_pos};

	// Advance parser state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= tfr_pkg::PH_IDLE;
			cur_type_q  <= '0;
			cur_len_q   <= '0;
			cur_id_q    <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			sent_q      <= '0;
			bank_q      <= 1'b0;
			last_type_q <= '0;
			last_id_q   <= '0;
			last_len_q  <= '0;
			good_q      <= '0;
			total_q     <= '0;
		end else if (in_fire) begin
			phase_q     <= phase_d;
			cur_type_q  <= cur_type_d;
			cur_len_q   <= cur_len_d;
			cur_id_q    <= cur_id_d;
			pos_q       <= pos_d;
			sum_q       <= sum_d;
			sent_q      <= sent_d;
			bank_q      <= bank_d;
			last_type_q <= last_type_d;
			last_id_q   <= last_id_d;
			last_len_q  <= last_len_d;
			good_q      <= good_d;
			total_q     <= total_d;
		end
	end

	// Payload store
	tfr_ram #(
		.WIDTH(8),
		.DEPTH(tfr_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (data_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Stage 1: result waits for RAM data; hold the data if stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			s1_fresh_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_valid_s1 <= 1'b1;
			end else if (s1_move) begin
				s1_valid_s1 <= 1'b0;
			end
			s1_fresh_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			s1_res_s1 <= res_d;
		end
		if (s1_fresh_s1) begin
			s1_hold_s1 <= ram_rdata;
		end
	end

	assign s1_byte = s1_res_s1.rok ? (s1_fresh_s1 ? ram_rdata : s1_hold_s1) : 8'd0;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_res_q  <= s1_res_s1;
			out_byte_q <= s1_byte;
		end
	end

	assign out_valid           = out_valid_q;
	assign frame_event         = out_res_q.ev;
	assign frame_type          = out_res_q.ftype;
	assign frame_id            = out_res_q.fid;
	assign frame_length        = out_res_q.flen;
	assign read_byte           = out_byte_q;
	assign read_ok             = out_res_q.rok;
	assign frames_good         = out_res_q.good;
	assign payload_bytes_total = out_res_q.total;

	// Checks
	a_write_rx_bank: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ram_waddr[tfr_pkg::STORE_AW-1] != bank_q)
		else $error("payload write hit the delivered bank");

	a_fresh_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fresh_s1 |-> s1_valid_s1)
		else $error("RAM data returned with no item in stage 1");

	a_rok_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_res_q.rok |-> out_res_q.ev == tfr_pkg::EV_READ)
		else $error("read_ok set on a non-read result");

	a_good_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_res_q.ev == tfr_pkg::EV_GOOD |-> out_res_q.flen <= MAX_LEN)
		else $error("delivered frame longer than the limit");

endmodule

`default_nettype wire
